// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the rotating substitution cipher.
// Every macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define RSC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// Check a same-cycle implication.
`define RSC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Check a next-cycle implication.
`define RSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

// ===== rtl/rsc_pkg.sv =====
// ---------------------------------------------------------------------------
// rsc_pkg
// Types, codes and constants for the rotating substitution cipher.
// ---------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

    localparam int LETTERS  = 26;
    localparam int LETTER_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int KEY_LOW_W  = 60;
    localparam int KEY_HIGH_W = 10;

    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7a;

    typedef logic [LETTER_W-1:0] letter_t;

    // Commands
    localparam logic [1:0] CMD_ENCRYPT   = 2'd0;
    localparam logic [1:0] CMD_DECRYPT   = 2'd1;
    localparam logic [1:0] CMD_ROT_RESET = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_KEY  = 2'd2;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_MID  = 2'd1;
    localparam logic [1:0] REG_KEY_HIGH = 2'd2;

    localparam letter_t LAST_LETTER = letter_t'(LETTERS - 1);

    // Key as seen by the datapath: forward table, inverse table, validity.
    typedef struct packed {
        logic                      ok;
        letter_t [LETTERS-1:0]     fwd;
        letter_t [LETTERS-1:0]     inv;
    } key_view_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] status;
        letter_t    rot_next;
    } cipher_res_t;

endpackage

`default_nettype wire

// ===== rtl/rsc_key_unit.sv =====
// ---------------------------------------------------------------------------
// rsc_key_unit
// Key registers behind the APB port, permutation check and inverse table.
// ---------------------------------------------------------------------------
`default_nettype none

module rsc_key_unit
    import rsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output key_view_t                  key
);

    logic [KEY_LOW_W-1:0]  key_low_reg;
    logic [KEY_LOW_W-1:0]  key_mid_reg;
    logic [KEY_HIGH_W-1:0] key_high_reg;
    logic [1:0]            reg_sel;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_mid_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_KEY_LOW:  key_low_reg  <= pwdata[KEY_LOW_W-1:0];
                REG_KEY_MID:  key_mid_reg  <= pwdata[KEY_LOW_W-1:0];
                REG_KEY_HIGH: key_high_reg <= pwdata[KEY_HIGH_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_KEY_LOW:  prdata = CFG_DATA_W'(key_low_reg);
            REG_KEY_MID:  prdata = CFG_DATA_W'(key_mid_reg);
            REG_KEY_HIGH: prdata = CFG_DATA_W'(key_high_reg);
            default:      prdata = '0;
        endcase
    end

    // Unpack letters, then check: all in range and every letter covered
    // means a permutation.
    always_comb
    begin
        logic [LETTERS-1:0] seen;
        logic               in_range;
        key.fwd  = '0;
        key.inv  = '0;
        seen     = '0;
        in_range = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            key.fwd[i]      = key_low_reg[LETTER_W*i +: LETTER_W];
            key.fwd[i + 12] = key_mid_reg[LETTER_W*i +: LETTER_W];
        end
        for (int i = 0; i < 2; i++)
            key.fwd[i + 24] = key_high_reg[LETTER_W*i +: LETTER_W];
        for (int i = 0; i < LETTERS; i++)
        begin
            if (key.fwd[i] > LAST_LETTER)
                in_range = 1'b0;
            for (int v = 0; v < LETTERS; v++)
            begin
                if (key.fwd[i] == letter_t'(v))
                begin
                    seen[v]  = 1'b1;
                    key.inv[v] = key.inv[v] | letter_t'(i);
                end
            end
        end
        key.ok = in_range & (&seen);
    end

endmodule

`default_nettype wire

// ===== rtl/rsc_cipher_unit.sv =====
// ---------------------------------------------------------------------------
// rsc_cipher_unit
// Single-pass substitution: encrypt, decrypt, rotation reset, error status.
// ---------------------------------------------------------------------------
`default_nettype none

module rsc_cipher_unit
    import rsc_pkg::*;
(
    input  wire logic [1:0]   cmd,
    input  wire logic [7:0]   in_char,
    input  wire letter_t      rot,
    input  wire key_view_t    key,
    output cipher_res_t       res
);

    logic       char_ok;
    letter_t    p;
    logic [5:0] enc_sum;
    letter_t    enc_idx;
    logic [5:0] dec_sum;
    letter_t    dec_letter;

    assign char_ok = (in_char >= LOWER_A) && (in_char <= LOWER_Z);
    assign p       = letter_t'(in_char - LOWER_A);

    // (p - r) mod 26 and (pos + r) mod 26, one conditional subtract each
    assign enc_sum = {1'b0, p} + 6'(LETTERS) - {1'b0, rot};
    assign enc_idx = (enc_sum >= 6'(LETTERS)) ? letter_t'(enc_sum - 6'(LETTERS))
                                              : letter_t'(enc_sum);
    assign dec_sum = {1'b0, key.inv[p]} + {1'b0, rot};
    assign dec_letter = (dec_sum >= 6'(LETTERS)) ? letter_t'(dec_sum - 6'(LETTERS))
                                                 : letter_t'(dec_sum);

    always_comb
    begin
        res.out_char = '0;
        res.status   = STATUS_OK;
        res.rot_next = rot;
        case (cmd)
            CMD_ROT_RESET:
                res.rot_next = '0;
            CMD_ENCRYPT, CMD_DECRYPT:
            begin
                if (!key.ok)
                    res.status = STATUS_BAD_KEY;
                else if (!char_ok)
                    res.status = STATUS_BAD_CHAR;
                else
                begin
                    if (cmd == CMD_ENCRYPT)
                        res.out_char = LOWER_A + {3'b000, key.fwd[enc_idx]};
                    else
                        res.out_char = LOWER_A + {3'b000, dec_letter};
                    res.rot_next = (rot == LAST_LETTER) ? '0 : rot + letter_t'(1);
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rotating_substitution_cipher_core.sv =====
// ---------------------------------------------------------------------------
// rotating_substitution_cipher_core
// Single-rotor substitution cipher, one character per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Write the 26-letter key through the APB port (low, mid, high words at
//   byte addresses 0x00, 0x08, 0x10) while no item is in flight.
//   Send items on item_valid/item_ready: cmd selects encrypt, decrypt or
//   rotation reset, in_char carries the byte. Each item yields exactly one
//   result on result_valid/result_ready with out_char and status.
//   An input transfer loads the input register; the item moves on into the
//   result register, which drives result_valid, once that register is free.
//   Throughput: one item per cycle while the receiver does not stall; the single
//   combinational pass between the two registers updates the rotor offset.
//   Reset clears the key registers, the rotor offset and both valid flags.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item; item_ready drops once both are full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rotating_substitution_cipher_core
    import rsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic [1:0]            cmd,
    input  wire logic [7:0]            in_char,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic      [7:0]            out_char,
    output logic      [1:0]            status
);

    key_view_t   key;
    cipher_res_t res;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [1:0] s1_cmd_reg;
    logic [7:0] s1_char_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic [1:0] status_reg;
    letter_t    rot_reg;
    letter_t    rot_next;
    logic       advance;
    logic       take;

    rsc_key_unit u_key (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    rsc_cipher_unit u_cipher (
        .cmd     (s1_cmd_reg),
        .in_char (s1_char_reg),
        .rot     (rot_reg),
        .key     (key),
        .res     (res)
    );

    // Move the input stage forward whenever the result register is free.
    assign advance    = !out_valid_reg || result_ready;
    assign item_ready = !s1_valid_reg || advance;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        rot_next       = rot_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        if (advance)
            out_valid_next = s1_valid_reg;
        if (advance && s1_valid_reg)
            rot_next = res.rot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rot_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            rot_reg       <= rot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_cmd_reg  <= cmd;
            s1_char_reg <= in_char;
        end
        if (advance && s1_valid_reg)
        begin
            out_char_reg <= res.out_char;
            status_reg   <= res.status;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_char     = out_char_reg;
    assign status       = status_reg;

    `RSC_ASSERT_ALWAYS(a_rot_in_range, rot_reg <= LAST_LETTER)
    `RSC_ASSERT_IMPLY(a_err_zero_char,
        out_valid_reg && (status_reg != STATUS_OK), out_char_reg == 8'h00)
    `RSC_ASSERT_IMPLY(a_char_lower,
        out_valid_reg && (out_char_reg != 8'h00),
        (out_char_reg >= LOWER_A) && (out_char_reg <= LOWER_Z))
    `RSC_ASSERT_NEXT(a_rot_reset,
        advance && s1_valid_reg && (s1_cmd_reg == CMD_ROT_RESET), rot_reg == '0)
    `RSC_ASSERT_NEXT(a_rot_hold_idle, !(advance && s1_valid_reg), $stable(rot_reg))

endmodule

`default_nettype wire

// ===== test/cipher_result_checker.sv =====
// ----------------------------------------------------------------------------
// cipher_result_checker
// Watches the configuration port and both item channels of the rotating
// substitution cipher core. Tracks its own copy of the key and rotor offset,
// works out the result of every input transfer and compares each result
// transfer, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module cipher_result_checker
    import rsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  logic [1:0]            cmd,
    input  logic [7:0]            in_char,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic [7:0]            out_char,
    input  logic [1:0]            status,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] status;
    } cipher_out_t;

    logic [KEY_LOW_W-1:0]  key_low;
    logic [KEY_LOW_W-1:0]  key_mid;
    logic [KEY_HIGH_W-1:0] key_high;
    letter_t               rotor;
    cipher_out_t           cipher_out_q [$];
    cipher_out_t           want;

    function automatic letter_t key_letter(input int idx);
        if (idx < 12)
            return key_low[LETTER_W*idx +: LETTER_W];
        else if (idx < 24)
            return key_mid[LETTER_W*(idx-12) +: LETTER_W];
        return key_high[LETTER_W*(idx-24) +: LETTER_W];
    endfunction

    function automatic logic key_is_permutation();
        logic [31:0] seen;
        letter_t     v;
        int          i;
        seen = '0;
        for (i = 0; i < LETTERS; i++)
        begin
            v = key_letter(i);
            if (v > LAST_LETTER || seen[v])
                return 1'b0;
            seen[v] = 1'b1;
        end
        return 1'b1;
    endfunction

    // Item result; steps the rotor on a good en/decrypt, zeroes it on rot reset.
    function automatic cipher_out_t cipher_step(input logic [1:0] op, input logic [7:0] ch);
        cipher_out_t res;
        int          plain;
        int          pos;
        int          i;
        res.out_char = 8'h00;
        res.status   = STATUS_OK;
        if (op == CMD_ROT_RESET)
            rotor = '0;
        else if (op == CMD_ENCRYPT || op == CMD_DECRYPT)
        begin
            if (!key_is_permutation())
                res.status = STATUS_BAD_KEY;
            else if (ch < LOWER_A || ch > LOWER_Z)
                res.status = STATUS_BAD_CHAR;
            else
            begin
                plain = ch - LOWER_A;
                if (op == CMD_ENCRYPT)
                    res.out_char = LOWER_A + key_letter((plain + LETTERS - rotor) % LETTERS);
                else
                begin
                    pos = 0;
                    for (i = 0; i < LETTERS; i++)
                        if (key_letter(i) == plain)
                            pos = i;
                    res.out_char = LOWER_A + (pos + rotor) % LETTERS;
                end
                rotor = (rotor == LAST_LETTER) ? '0 : rotor + 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] cipher check: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low    = '0;
            key_mid    = '0;
            key_high   = '0;
            rotor      = '0;
            fail_count = 0;
            cipher_out_q.delete();
            pending <= 0;
        end
        else
        begin
            // a result can never belong to the item taken at the same edge
            if (result_valid && result_ready)
            begin
                if (cipher_out_q.size() == 0)
                    report_mismatch($sformatf("unexpected result out_char=%h status=%0d",
                                              out_char, status));
                else
                begin
                    want = cipher_out_q.pop_front();
                    if (out_char !== want.out_char)
                        report_mismatch($sformatf("out_char %h, expected %h",
                                                  out_char, want.out_char));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:3])
                    REG_KEY_LOW:  key_low  = pwdata[KEY_LOW_W-1:0];
                    REG_KEY_MID:  key_mid  = pwdata[KEY_LOW_W-1:0];
                    REG_KEY_HIGH: key_high = pwdata[KEY_HIGH_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
                cipher_out_q.push_back(cipher_step(cmd, in_char));
            pending <= cipher_out_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the rotating substitution cipher core: key loads over the APB port,
// a directed run over bad keys, bad bytes and every command, then random
// phases with different sender and receiver idling and two long receiver
// hold-offs. Checking is done by the result checker placed beside the core.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int HEAVY_PCT    = 57;
    localparam int LIGHT_PCT    = 23;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    logic [1:0]            cmd          = CMD_ENCRYPT;
    logic [7:0]            in_char      = 8'h00;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [7:0]            out_char;
    logic [1:0]            status;

    int      fail_count;
    int      pending;
    int      idle_pct      = 0;
    int      stall_pct     = 0;
    int      hold_requests = 0;
    letter_t key_buf [LETTERS];

    rotating_substitution_cipher_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .in_char      (in_char),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_char     (out_char),
        .status       (status)
    );

    cipher_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .in_char      (in_char),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_char     (out_char),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : receiver
        int hold_served;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_served++;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic load_regs(input logic [CFG_DATA_W-1:0] low_word,
                             input logic [CFG_DATA_W-1:0] mid_word,
                             input logic [CFG_DATA_W-1:0] high_word);
        write_reg(REG_KEY_LOW, low_word);
        write_reg(REG_KEY_MID, mid_word);
        write_reg(REG_KEY_HIGH, high_word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_key();
        logic [CFG_DATA_W-1:0] low_word;
        logic [CFG_DATA_W-1:0] mid_word;
        logic [CFG_DATA_W-1:0] high_word;
        int                    i;
        low_word  = '0;
        mid_word  = '0;
        high_word = '0;
        for (i = 0; i < 12; i++)
        begin
            low_word[LETTER_W*i +: LETTER_W] = key_buf[i];
            mid_word[LETTER_W*i +: LETTER_W] = key_buf[12+i];
        end
        high_word[LETTER_W-1:0]          = key_buf[24];
        high_word[2*LETTER_W-1:LETTER_W] = key_buf[25];
        load_regs(low_word, mid_word, high_word);
    endtask

    task automatic shuffle_key();
        letter_t tmp;
        int      i;
        int      j;
        for (i = 0; i < LETTERS; i++)
            key_buf[i] = letter_t'(i);
        for (i = LETTERS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp        = key_buf[i];
            key_buf[i] = key_buf[j];
            key_buf[j] = tmp;
        end
    endtask

    // Offer one item and hold it until the transfer; leave valid high after it.
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
        if ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= op;
        in_char    <= ch;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic send_random_item();
        logic [1:0] op;
        logic [7:0] ch;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 48)
            op = CMD_ENCRYPT;
        else if (pick < 94)
            op = CMD_DECRYPT;
        else if (pick < 97)
            op = CMD_ROT_RESET;
        else
            op = CMD_UNUSED;
        if ($urandom_range(99) < 85)
            ch = LOWER_A + 8'($urandom_range(LETTERS - 1));
        else
            ch = 8'($urandom_range(255));
        send_item(op, ch);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int p;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // key after reset is all zeros: repeated letter
        send_item(CMD_ENCRYPT, LOWER_A);
        send_item(CMD_DECRYPT, 8'hFF);
        send_item(CMD_ROT_RESET, 8'h71);
        send_item(CMD_UNUSED, 8'h62);
        drain();

        // letter fields above the alphabet
        load_regs('1, '1, '1);
        send_item(CMD_ENCRYPT, 8'h6D);
        drain();

        shuffle_key();
        load_key();
        send_item(CMD_ENCRYPT, LOWER_A);
        send_item(CMD_ENCRYPT, LOWER_Z);
        send_item(CMD_DECRYPT, LOWER_A);
        send_item(CMD_DECRYPT, LOWER_Z);
        send_item(CMD_ENCRYPT, 8'h60);
        send_item(CMD_DECRYPT, 8'h7B);
        send_item(CMD_ENCRYPT, 8'h00);
        send_item(CMD_DECRYPT, 8'hFF);
        send_item(CMD_ENCRYPT, 8'h41);
        send_item(CMD_UNUSED, 8'h63);
        send_item(CMD_DECRYPT, 8'h6B);
        send_item(CMD_ROT_RESET, 8'h00);
        send_item(CMD_DECRYPT, 8'h6B);
        drain();

        // duplicated letter; rotor must survive the rewrite
        key_buf[3] = key_buf[17];
        load_key();
        send_item(CMD_DECRYPT, 8'h6B);
        send_item(CMD_ENCRYPT, 8'hC0);
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            shuffle_key();
            if (p == 5)
                key_buf[7] = key_buf[19];
            load_key();
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = HEAVY_PCT;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = HEAVY_PCT;
                end
                default:
                begin
                    idle_pct  = LIGHT_PCT;
                    stall_pct = LIGHT_PCT;
                end
            endcase
            // hold the receiver off while items keep coming, filling the core
            if (p == 0 || p == 4)
                hold_requests++;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== rotating_substitution_cipher_core.f =====
+incdir+rtl
rtl/rsc_pkg.sv
rtl/rsc_key_unit.sv
rtl/rsc_cipher_unit.sv
rtl/rotating_substitution_cipher_core.sv
test/cipher_result_checker.sv
test/testbench.sv
